FILE: rtl/slc_pkg.sv
// Shared types and constants for the sequential list engine.
package slc_pkg;

    // Request operation codes
    localparam logic [2:0] OP_APPEND  = 3'd0;
    localparam logic [2:0] OP_INSERT  = 3'd1;
    localparam logic [2:0] OP_RMV_VAL = 3'd2;
    localparam logic [2:0] OP_RMV_POS = 3'd3;
    localparam logic [2:0] OP_LOCATE  = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;

    // Fixed field widths of the request and response words
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int CNT_W  = 7;
    localparam int FPOS_W = 6;

    // Match scanner: cells examined per cycle and width of the in-group offset
    localparam int SCAN_GROUP = 8;
    localparam int SCAN_LW    = 3;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } req_word_t;

    typedef struct packed {
        logic                     ok;
        logic [FPOS_W-1:0]        found_position;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         item_count;
        logic                     is_empty;
        logic                     is_full;
    } rsp_word_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic ins;
        logic del;
        logic cmp;
    } cell_ctl_t;

    // Status from the match scanner
    typedef struct packed {
        logic done;
        logic hit;
    } scan_stat_t;

endpackage

FILE: rtl/slc_cell.sv
// One list cell: holds one entry, shifts with its neighbors, flags a key match.
module slc_cell #(
    parameter int IDX = 0,
    parameter int VW  = 32,
    parameter int PW  = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  slc_pkg::cell_ctl_t ctl,
    input  logic [PW-1:0]     tgt,
    input  logic [PW-1:0]     cnt,
    input  logic [VW-1:0]     new_word,
    input  logic [VW-1:0]     key,
    input  logic [VW-1:0]     prev_word,
    input  logic [VW-1:0]     next_word,
    output logic [VW-1:0]     word,
    output logic              match
);

    localparam logic [PW-1:0] ME  = PW'(IDX);
    localparam logic [PW-1:0] ME1 = PW'(IDX + 1);

    logic [VW-1:0] word_reg;
    logic [VW-1:0] word_next;
    logic          match_reg;
    logic          match_next;

    // Take the new word, the lower neighbor on insert, the upper one on delete
    always_comb
    begin
        word_next = word_reg;
        if (ctl.ins)
        begin
            if (ME == tgt)
                word_next = new_word;
            else if ((ME > tgt) && (ME <= cnt))
                word_next = prev_word;
        end
        else if (ctl.del)
        begin
            if ((ME >= tgt) && (ME1 < cnt))
                word_next = next_word;
        end
    end

    // Compare against the key only for live entries
    always_comb
    begin
        match_next = match_reg;
        if (ctl.cmp)
            match_next = (word_reg == key) && (ME < cnt);
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

    assign word  = word_reg;
    assign match = match_reg;

endmodule

FILE: rtl/slc_scan.sv
// Priority scanner: walks the cell match flags one group per cycle.
module slc_scan #(
    parameter int CAPACITY = 64,
    parameter int PW       = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CAPACITY-1:0] match,
    output slc_pkg::scan_stat_t stat,
    output logic [PW-1:0]       idx
);

    import slc_pkg::*;

    localparam int G  = SCAN_GROUP;
    localparam int NG = (CAPACITY + G - 1) / G;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;

    logic [NG*G-1:0]    padded;
    logic [G-1:0]       grp;
    logic [SCAN_LW-1:0] lo;
    logic               any;
    logic               last;
    logic               busy_reg;
    logic               busy_next;
    logic [GW-1:0]      gidx_reg;
    logic [GW-1:0]      gidx_next;

    assign padded = (NG*G)'(match);
    assign grp    = padded[gidx_reg*G +: G];
    assign last   = (gidx_reg == GW'(NG - 1));

    // Lowest set flag in the current group
    always_comb
    begin
        lo  = '0;
        any = 1'b0;
        for (int k = G - 1; k >= 0; k--)
        begin
            if (grp[k])
            begin
                lo  = SCAN_LW'(k);
                any = 1'b1;
            end
        end
    end

    // Advance one group until a hit or the end of the row
    always_comb
    begin
        busy_next = busy_reg;
        gidx_next = gidx_reg;
        if (start)
        begin
            busy_next = 1'b1;
            gidx_next = '0;
        end
        else if (busy_reg)
        begin
            if (any || last)
                busy_next = 1'b0;
            else
                gidx_next = gidx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            gidx_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            gidx_reg <= gidx_next;
        end
    end

    assign stat.done = busy_reg && (any || last);
    assign stat.hit  = busy_reg && any;
    assign idx       = PW'({gidx_reg, lo});

endmodule

FILE: rtl/sequential_list_engine.sv
// Ordered list of up to CAPACITY words kept in a chain of cells. Each word on the
// request side carries one operation and yields one response word. Append, insert,
// remove at a position, read and unsupported codes are captured, then, for an insert
// or remove, every cell shifts or loads at once. Locate and remove by value pass a
// compare state, where every cell flags a key match, and a scan state, where the
// priority scanner walks the match flags in groups of eight, 1 to ceil(CAPACITY/8)
// groups (8 at the default size), until it finds the first match or reaches the end
// of the row. One request is in work at a time; a finished response waits in an
// output register, so the next request is taken while it is still stalled.
// No clearing pass follows reset: entries beyond the count are never read.
module sequential_list_engine #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  slc_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output slc_pkg::rsp_word_t rsp
);

    import slc_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EXEC = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [2:0]          op_reg;
    logic [VW-1:0]       key_reg;
    logic [PW-1:0]       tgt_reg;
    logic                found_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                rsp_valid_reg;
    rsp_word_t           rsp_reg;
    rsp_word_t           rsp_next;

    logic                accept;
    logic                fire;
    logic [VW+DATA_W-1:0] vext;
    logic [VW-1:0]       key_in;
    logic [PW-1:0]       cnt_p;
    logic                not_full;
    logic                in_range;
    logic                ins_ok;
    logic                del_ok;
    logic                loc_ok;
    logic                rd_ok;
    logic [VW+DATA_W-1:0] rext;

    cell_ctl_t           ctl;
    logic [VW-1:0]       words [CAPACITY];
    logic [CAPACITY-1:0] match;
    scan_stat_t          scan_stat;
    logic [PW-1:0]       scan_idx;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign fire      = (state_reg == ST_EXEC) && (!rsp_valid_reg || !rsp_stall);

    // Keep the low VALUE_WIDTH bits of the request value
    assign vext   = {{VW{1'b0}}, req.value};
    assign key_in = vext[VW-1:0];

    assign cnt_p    = PW'(count_reg);
    assign not_full = (count_reg != CW'(CAPACITY));
    assign in_range = (tgt_reg < cnt_p);

    // Decide the outcome of the captured request
    always_comb
    begin
        ins_ok = 1'b0;
        del_ok = 1'b0;
        loc_ok = 1'b0;
        rd_ok  = 1'b0;
        case (op_reg)
            OP_APPEND, OP_INSERT: ins_ok = not_full && (tgt_reg <= cnt_p);
            OP_RMV_VAL:           del_ok = found_reg;
            OP_RMV_POS:           del_ok = in_range;
            OP_LOCATE:            loc_ok = found_reg;
            OP_READ:              rd_ok  = in_range;
            default:
            begin
                ins_ok = 1'b0;
            end
        endcase
    end

    // Drive the cell row
    assign ctl.ins = fire && ins_ok;
    assign ctl.del = fire && del_ok;
    assign ctl.cmp = (state_reg == ST_CMP);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VW-1:0] prev_w;
        logic [VW-1:0] next_w;

        if (i == 0)
        begin : g_first
            assign prev_w = key_reg;
        end
        else
        begin : g_prev
            assign prev_w = words[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_w = key_reg;
        end
        else
        begin : g_next
            assign next_w = words[i+1];
        end

        slc_cell #(
            .IDX (i),
            .VW  (VW),
            .PW  (PW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .tgt       (tgt_reg),
            .cnt       (cnt_p),
            .new_word  (key_reg),
            .key       (key_reg),
            .prev_word (prev_w),
            .next_word (next_w),
            .word      (words[i]),
            .match     (match[i])
        );
    end

    slc_scan #(
        .CAPACITY (CAPACITY),
        .PW       (PW)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_CMP),
        .match (match),
        .stat  (scan_stat),
        .idx   (scan_idx)
    );

    // Count after the operation
    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
            count_next = count_reg + 1'b1;
        else if (ctl.del)
            count_next = count_reg - 1'b1;
    end

    // Build the response word
    assign rext = {{DATA_W{1'b0}}, words[tgt_reg[IW-1:0]]};

    always_comb
    begin
        rsp_next.ok             = ins_ok || del_ok || loc_ok || rd_ok;
        rsp_next.found_position = loc_ok ? tgt_reg[FPOS_W-1:0] : '0;
        rsp_next.read_value     = rd_ok ? rext[DATA_W-1:0] : '0;
        rsp_next.item_count     = CNT_W'(count_next);
        rsp_next.is_empty       = (count_next == '0);
        rsp_next.is_full        = (count_next == CW'(CAPACITY));
    end

    // Sequence one request at a time
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.op inside {OP_RMV_VAL, OP_LOCATE})
                        state_next = ST_CMP;
                    else
                        state_next = ST_EXEC;
                end
            end
            ST_CMP:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_stat.done)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (fire)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (fire)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
            if (accept)
                found_reg <= 1'b0;
            else if ((state_reg == ST_SCAN) && scan_stat.done)
                found_reg <= scan_stat.hit;
        end
    end

    // Hold the request fields and the target position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.op;
            key_reg <= key_in;
            if (req.op == OP_APPEND)
                tgt_reg <= cnt_p;
            else
                tgt_reg <= PW'(req.position);
        end
        else if ((state_reg == ST_SCAN) && scan_stat.hit)
        begin
            tgt_reg <= scan_idx;
        end
        if (fire)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/slc_checker.sv
// Port-level checks for the sequential list engine, bound to the top level.
module slc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input slc_pkg::rsp_word_t rsp
);

    import slc_pkg::*;

    logic             req_fire;
    logic             rsp_fire;
    logic [1:0]       pend_reg;
    logic [CNT_W-1:0] last_cnt_reg;

    assign req_fire = req_valid && !req_stall;
    assign rsp_fire = rsp_valid && !rsp_stall;

    // Track requests in flight and the last count reported
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= '0;
            last_cnt_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, req_fire} - {1'b0, rsp_fire};
            if (rsp_fire)
                last_cnt_reg <= rsp.item_count;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response without a pending request");

    a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && !rsp.ok |-> rsp.item_count == last_cnt_reg)
        else $error("rejected request changed the count");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire |-> (rsp.item_count == last_cnt_reg)
                  || (rsp.item_count == last_cnt_reg + 7'd1)
                  || (last_cnt_reg == rsp.item_count + 7'd1))
        else $error("count moved by more than one");

endmodule

bind sequential_list_engine slc_checker u_slc_checker (.*);
